// ----- hdl/aging_priority_task_scheduler_defines.svh -----
// ------------------------------------------------------------------------
// aging priority task scheduler assertion macros
// shared assertion shorthands, removable with NO_ASSERTIONS
// ------------------------------------------------------------------------
`ifndef AGING_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define AGING_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define APS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
`define APS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define APS_ASSERT_IMP(label, ante, cons)
`define APS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- hdl/aps_pkg.sv -----
// ------------------------------------------------------------------------
// aps_pkg
// types, widths and codes shared by the scheduler modules
// ------------------------------------------------------------------------
package aps_pkg;

    localparam int TASKS  = 8;
    localparam int ID_W   = 3;
    localparam int CNT_W  = 4;
    localparam int PRIO_W = 8;
    localparam int TICK_W = 32;
    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

    localparam logic [2:0] OP_CREATE    = 3'd0;
    localparam logic [2:0] OP_TICK      = 3'd1;
    localparam logic [2:0] OP_DELAY     = 3'd2;
    localparam logic [2:0] OP_YIELD     = 3'd3;
    localparam logic [2:0] OP_START     = 3'd4;
    localparam logic [2:0] OP_TERMINATE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_TASK = 2'd2;

    localparam logic [2:0] KM_NONE = 3'd0;
    localparam logic [2:0] KM_HEAD = 3'd1;
    localparam logic [2:0] KM_ID   = 3'd2;
    localparam logic [2:0] KM_DUE  = 3'd3;
    localparam logic [2:0] KM_BEST = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] wake;
    } t_ent;

    typedef struct packed {
        logic              push;
        t_ent              push_ent;
        logic [2:0]        kill_mode;
        logic [ID_W-1:0]   kill_id;
        logic [TICK_W-1:0] tick;
        logic              age;
        logic [PRIO_W-1:0] ceiling;
    } t_qctl;

    typedef struct packed {
        logic hit;
        logic empty;
        t_ent ent;
    } t_qres;

endpackage

// ----- hdl/aps_cell.sv -----
// ------------------------------------------------------------------------
// aps_cell
// one queue slot: holds an entry, shifts left on removal, ages, takes pushes
// ------------------------------------------------------------------------
module aps_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aps_pkg::t_qctl             i_ctl,
    input  logic                       i_head,
    input  logic                       i_left_valid,
    input  aps_pkg::t_ent              i_right_ent,
    input  logic                       i_shift_in,
    input  logic [aps_pkg::PRIO_W-1:0] i_max_in,
    input  logic                       i_max_vld_in,
    input  logic                       i_cand_after,
    output aps_pkg::t_ent              o_ent,
    output logic                       o_shift_out,
    output logic [aps_pkg::PRIO_W-1:0] o_max_out,
    output logic                       o_max_vld_out,
    output logic                       o_cand_out,
    output logic                       o_kill
);

    aps_pkg::t_ent r_ent;
    aps_pkg::t_ent n_ent;
    logic          cand;

    // strictly above everything to the left: last such cell holds the first maximum
    assign cand          = r_ent.valid && (!i_max_vld_in || r_ent.prio > i_max_in);
    assign o_max_out     = cand ? r_ent.prio : i_max_in;
    assign o_max_vld_out = i_max_vld_in || r_ent.valid;
    assign o_cand_out    = cand || i_cand_after;

    always_comb begin
        case (i_ctl.kill_mode)
            aps_pkg::KM_HEAD: o_kill = i_head && r_ent.valid;
            aps_pkg::KM_ID:   o_kill = r_ent.valid && r_ent.id == i_ctl.kill_id;
            aps_pkg::KM_DUE:  o_kill = r_ent.valid && i_ctl.tick >= r_ent.wake && !i_shift_in;
            aps_pkg::KM_BEST: o_kill = cand && !i_cand_after;
            default:          o_kill = 1'b0;
        endcase
    end

    assign o_shift_out = i_shift_in || o_kill;
    assign o_ent       = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (o_shift_out) begin
            n_ent = i_right_ent;
        end else if (i_ctl.push && !r_ent.valid && i_left_valid) begin
            n_ent       = i_ctl.push_ent;
            n_ent.valid = 1'b1;
        end else if (i_ctl.age && r_ent.valid && r_ent.prio < i_ctl.ceiling
                     && r_ent.prio < aps_pkg::PRIO_MAX) begin
            n_ent.prio = r_ent.prio + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else begin
            r_ent <= n_ent;
        end
    end

endmodule

// ----- hdl/aps_queue.sv -----
// ------------------------------------------------------------------------
// aps_queue
// ordered task queue built as a row of cells, head at cell 0
// ------------------------------------------------------------------------
module aps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aps_pkg::t_qctl i_ctl,
    output aps_pkg::t_qres o_res
);

    localparam int N = aps_pkg::TASKS;

    aps_pkg::t_ent               ents  [N];
    logic                        shift [N+1];
    logic [aps_pkg::PRIO_W-1:0]  mx    [N+1];
    logic                        mxv   [N+1];
    logic                        cand  [N+1];
    logic [N-1:0]                kill;

    assign shift[0]  = 1'b0;
    assign mx[0]     = '0;
    assign mxv[0]    = 1'b0;
    assign cand[N]   = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        aps_pkg::t_ent right_ent;
        logic          left_valid;
        if (g == N - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_mid
            assign right_ent = ents[g+1];
        end
        if (g == 0) begin : g_first
            assign left_valid = 1'b1;
        end else begin : g_rest
            assign left_valid = ents[g-1].valid;
        end
        aps_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_head        (g == 0),
            .i_left_valid  (left_valid),
            .i_right_ent   (right_ent),
            .i_shift_in    (shift[g]),
            .i_max_in      (mx[g]),
            .i_max_vld_in  (mxv[g]),
            .i_cand_after  (cand[g+1]),
            .o_ent         (ents[g]),
            .o_shift_out   (shift[g+1]),
            .o_max_out     (mx[g+1]),
            .o_max_vld_out (mxv[g+1]),
            .o_cand_out    (cand[g]),
            .o_kill        (kill[g])
        );
    end

    always_comb begin
        o_res       = '0;
        o_res.hit   = |kill;
        o_res.empty = !ents[0].valid;
        for (int i = 0; i < N; i++) begin
            o_res.ent = o_res.ent | (kill[i] ? ents[i] : '0);
        end
    end

endmodule

// ----- hdl/aging_priority_task_scheduler.sv -----
// ------------------------------------------------------------------------
// aging_priority_task_scheduler
// task scheduler with ready and sleep queues held in cell chains, aging
// of ready priorities and first-maximum selection
// ------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | op, priority_req, delay_ticks, task_id
//  out     | output    | o_out_valid / i_out_stall  | running_task .. status
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | priority_ceiling
//
// one item at a time: create, start and plain ops go straight to done, yield, delay and
// terminate of the current task pass through requeue and pick, a tick through wake, age,
// requeue and pick; the sleep walk moves one due task per cycle through the chain.
// synchronous active-low reset empties both queues and clears the counters.
// the result register frees the input side: a stalled result holds only the
// next item in its final cycle.
module aging_priority_task_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_delay_ticks,
    input  logic [2:0]  i_task_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_running_task,
    output logic        o_running_valid,
    output logic        o_switched,
    output logic [2:0]  o_new_task_id,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

`include "aging_priority_task_scheduler_defines.svh"

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_WAKE     = 3'd1;
    localparam logic [2:0] S_AGE      = 3'd2;
    localparam logic [2:0] S_REQUEUE  = 3'd3;
    localparam logic [2:0] S_PICK     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [7:0]                  r_ceil;
    logic [aps_pkg::TICK_W-1:0]  r_tick, n_tick;
    logic [aps_pkg::CNT_W-1:0]   r_total, n_total;
    logic                        r_cur_valid, n_cur_valid;
    logic                        r_cur_run, n_cur_run;
    logic [aps_pkg::ID_W-1:0]    r_cur_id, n_cur_id;
    logic [aps_pkg::PRIO_W-1:0]  r_cur_prio, n_cur_prio;
    logic                        r_prev_valid, n_prev_valid;
    logic [aps_pkg::ID_W-1:0]    r_prev_id, n_prev_id;
    logic                        r_sw, n_sw;
    logic [aps_pkg::ID_W-1:0]    r_newid, n_newid;
    logic [1:0]                  r_status, n_status;
    logic                        r_out_valid;
    logic [2:0]                  r_o_task;
    logic                        r_o_valid;
    logic                        r_o_sw;
    logic [2:0]                  r_o_newid;
    logic [1:0]                  r_o_status;

    aps_pkg::t_qctl rq_ctl, sq_ctl;
    aps_pkg::t_qres rq_res, sq_res;
    logic           accept;
    logic           load_out;
    logic [aps_pkg::PRIO_W-1:0] req_prio;

    aps_queue u_ready (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(rq_ctl), .o_res(rq_res));
    aps_queue u_sleep (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(sq_ctl), .o_res(sq_res));

    assign o_in_stall  = r_state != S_IDLE;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign load_out    = r_state == S_DONE && (!r_out_valid || !i_out_stall);
    assign req_prio    = (i_priority_req > aps_pkg::PRIO_MAX) ? aps_pkg::PRIO_MAX
                                                              : i_priority_req;

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_total      = r_total;
        n_cur_valid  = r_cur_valid;
        n_cur_run    = r_cur_run;
        n_cur_id     = r_cur_id;
        n_cur_prio   = r_cur_prio;
        n_prev_valid = r_prev_valid;
        n_prev_id    = r_prev_id;
        n_sw         = r_sw;
        n_newid      = r_newid;
        n_status     = r_status;
        rq_ctl           = '0;
        rq_ctl.tick      = r_tick;
        rq_ctl.ceiling   = r_ceil;
        rq_ctl.kill_id   = i_task_id;
        rq_ctl.kill_mode = aps_pkg::KM_NONE;
        sq_ctl           = rq_ctl;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sw     = 1'b0;
                    n_newid  = '0;
                    n_status = aps_pkg::ST_OK;
                    n_state  = S_DONE;
                    case (i_op)
                        aps_pkg::OP_CREATE: begin
                            if (r_total == aps_pkg::CNT_W'(aps_pkg::TASKS)) begin
                                n_status = aps_pkg::ST_FULL;
                            end else begin
                                rq_ctl.push          = 1'b1;
                                rq_ctl.push_ent.id   = r_total[aps_pkg::ID_W-1:0];
                                rq_ctl.push_ent.prio = req_prio;
                                n_newid              = r_total[aps_pkg::ID_W-1:0];
                                n_total              = r_total + 1'b1;
                            end
                        end
                        aps_pkg::OP_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_state = S_WAKE;
                        end
                        aps_pkg::OP_DELAY: begin
                            if (!r_cur_valid || !r_cur_run) begin
                                n_status = aps_pkg::ST_NO_TASK;
                            end else begin
                                sq_ctl.push          = 1'b1;
                                sq_ctl.push_ent.id   = r_cur_id;
                                sq_ctl.push_ent.prio = r_cur_prio;
                                sq_ctl.push_ent.wake = r_tick + i_delay_ticks;
                                n_cur_run            = 1'b0;
                                n_state              = S_REQUEUE;
                            end
                        end
                        aps_pkg::OP_YIELD: begin
                            n_state = S_REQUEUE;
                        end
                        aps_pkg::OP_START: begin
                            if (!r_cur_valid) begin
                                if (rq_res.empty) begin
                                    n_status = aps_pkg::ST_NO_TASK;
                                end else begin
                                    rq_ctl.kill_mode = aps_pkg::KM_HEAD;
                                    n_cur_valid      = 1'b1;
                                    n_cur_run        = 1'b1;
                                    n_cur_id         = rq_res.ent.id;
                                    n_cur_prio       = rq_res.ent.prio;
                                end
                            end
                        end
                        aps_pkg::OP_TERMINATE: begin
                            if ({1'b0, i_task_id} < r_total) begin
                                rq_ctl.kill_mode = aps_pkg::KM_ID;
                                sq_ctl.kill_mode = aps_pkg::KM_ID;
                                if (r_cur_valid && r_cur_id == i_task_id) begin
                                    n_cur_run = 1'b0;
                                    n_state   = S_REQUEUE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WAKE: begin
                // one due sleeper per cycle, in sleep order
                sq_ctl.kill_mode = aps_pkg::KM_DUE;
                if (sq_res.hit) begin
                    rq_ctl.push     = 1'b1;
                    rq_ctl.push_ent = sq_res.ent;
                end else begin
                    n_state = S_AGE;
                end
            end
            S_AGE: begin
                rq_ctl.age = 1'b1;
                n_state    = S_REQUEUE;
            end
            S_REQUEUE: begin
                n_prev_valid = r_cur_valid;
                n_prev_id    = r_cur_id;
                if (r_cur_valid && r_cur_run) begin
                    rq_ctl.push          = 1'b1;
                    rq_ctl.push_ent.id   = r_cur_id;
                    rq_ctl.push_ent.prio = r_cur_prio;
                    n_cur_run            = 1'b0;
                end
                n_state = S_PICK;
            end
            S_PICK: begin
                if (!rq_res.empty) begin
                    rq_ctl.kill_mode = aps_pkg::KM_BEST;
                    n_cur_valid      = 1'b1;
                    n_cur_run        = 1'b1;
                    n_cur_id         = rq_res.ent.id;
                    n_cur_prio       = rq_res.ent.prio;
                    n_sw             = r_prev_valid && r_prev_id != rq_res.ent.id;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur_prio   <= n_cur_prio;
        r_prev_valid <= n_prev_valid;
        r_prev_id    <= n_prev_id;
        r_sw         <= n_sw;
        r_newid      <= n_newid;
        r_status     <= n_status;
        if (load_out) begin
            r_o_task    <= r_cur_valid ? r_cur_id : '0;
            r_o_valid   <= r_cur_valid;
            r_o_sw      <= r_sw;
            r_o_newid   <= r_newid;
            r_o_status  <= r_status;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ceil      <= 8'hff;
            r_tick      <= '0;
            r_total     <= '0;
            r_cur_valid <= 1'b0;
            r_cur_run   <= 1'b0;
            r_cur_id    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_total     <= n_total;
            r_cur_valid <= n_cur_valid;
            r_cur_run   <= n_cur_run;
            r_cur_id    <= n_cur_id;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ceil <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_running_task  = r_o_task;
    assign o_running_valid = r_o_valid;
    assign o_switched      = r_o_sw;
    assign o_new_task_id   = r_o_newid;
    assign o_status        = r_o_status;

    `APS_ASSERT_NXT(a_busy_after_accept, accept, o_in_stall)
    `APS_ASSERT_IMP(a_switch_needs_task, o_out_valid && o_switched, o_running_valid)
    `APS_ASSERT_IMP(a_idle_task_zero, o_out_valid && !o_running_valid, o_running_task == 3'd0)
    `APS_ASSERT_IMP(a_error_no_switch, o_out_valid && o_status != aps_pkg::ST_OK, !o_switched)

endmodule
